FILE: src/rcc_pkg.sv
// Shared constants and types for the row convolution with edge clamping.
package rcc_pkg;

  // Kernel geometry
  localparam int unsigned MaxTaps = 5;
  localparam int unsigned MaxHalf = (MaxTaps - 1) / 2;
  localparam int unsigned AgeW    = $clog2(MaxTaps);

  // Register and field widths
  localparam int unsigned HalfW    = 2;
  localparam int unsigned RowW     = 13;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned FiltW    = 27;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHalfWidth = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRowWidth  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoef0     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoef1     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoef2     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCoef3     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCoef4     = 3'd6;

  // Reset values of the configuration registers
  localparam logic [HalfW-1:0] HalfReset = 2'd1;
  localparam logic [RowW-1:0]  RowReset  = 13'd800;

  typedef logic signed [CoefW-1:0] coef_t;

  localparam coef_t CoefReset [MaxTaps] = '{16'sd1, 16'sd2, 16'sd1, 16'sd0, 16'sd0};

  // Pending output burst of one input pixel
  typedef struct packed {
    logic [HalfW-1:0] lag;       // distance of the current output column from newest pixel
    logic [HalfW-1:0] dist_end;  // distance of the last output of the burst
    logic [HalfW-1:0] half;      // effective half width
    logic [AgeW-1:0]  col_lim;   // newest column, limited to the window depth
    logic             last;      // the pixel closed its row
  } work_t;

endpackage

FILE: src/row_convolution_clamp_edge.sv
// Horizontal 1-D convolution of a pixel row with clamp-to-edge borders.
//
// Pixels enter in raster order on the in_valid_i/in_ready_o channel (pixel_i).
// Results leave on out_valid_o/out_ready_i: filtered_o is the signed weighted sum,
// row_end_o marks the last output of a row, burst_last_o the last output caused
// by one input pixel. The cfg channel writes half_width, row_width and coef_0..4
// by index; cfg_ready_o is always high. Writes must land only while the block is
// idle; the block does not enforce this. Output column x is produced when pixel
// x+half_width arrives, so the first half_width pixels of a row produce nothing.
// The last pixel of a row produces the remaining outputs (up to half_width+1)
// as one burst. A pixel is registered in the burst descriptor, then its result
// in the result register. A pixel is taken every cycle unless a burst or the
// receiver holds it; row-end bursts share the single result register, so the input
// stalls at row end. A stalled receiver holds the result register and the input.
// Reset loads the register defaults (half_width 1, row_width 800, kernel 1 2 1)
// and restarts at column zero; the pixel window is not cleared.
module row_convolution_clamp_edge
  import rcc_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = 4096,
  parameter int unsigned PIXEL_BITS    = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // pixel requests
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [PIXEL_BITS-1:0]      pixel_i,
  // result requests
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [FiltW-1:0]    filtered_o,
  output logic                       row_end_o,
  output logic                       burst_last_o,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned ColW   = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned WidthW = ($clog2(MAX_ROW_WIDTH + 1) > RowW) ?
                                   $clog2(MAX_ROW_WIDTH + 1) : RowW;
  localparam int unsigned ProdW  = CoefW + PIXEL_BITS + 1;
  localparam int unsigned AccW   = (ProdW + AgeW > FiltW) ? ProdW + AgeW : FiltW;
  localparam logic [WidthW-1:0] MaxWidth = WidthW'(MAX_ROW_WIDTH);

  // Configuration registers
  logic [HalfW-1:0] half_q;
  logic [RowW-1:0]  row_width_q;
  coef_t            coef_q [MaxTaps];

  // Stream state
  logic [ColW-1:0]       col_q;
  logic [PIXEL_BITS-1:0] win_q [MaxTaps];
  logic                  wk_valid_q;
  work_t                 wk_q;

  // Result register
  logic                    out_valid_q;
  logic signed [FiltW-1:0] filt_q;
  logic                    row_end_q;
  logic                    burst_last_q;

  // Derived per-pixel values
  logic [HalfW-1:0]  half_eff;
  logic [WidthW-1:0] width_ext;
  logic [WidthW-1:0] width_eff;
  logic [WidthW-1:0] col_ext;
  logic              is_last;
  logic              has_res;
  logic [AgeW-1:0]   col_lim;
  logic [HalfW-1:0]  dist_start;
  logic              in_fire;
  logic              wk_fire;
  logic              wk_done;
  logic signed [AccW-1:0] acc;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= HalfReset;
      row_width_q <= RowReset;
      for (int i = 0; i < MaxTaps; i++) begin
        coef_q[i] <= CoefReset[i];
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegHalfWidth: half_q      <= cfg_data_i[HalfW-1:0];
        RegRowWidth:  row_width_q <= cfg_data_i[RowW-1:0];
        RegCoef0:     coef_q[0]   <= coef_t'(cfg_data_i);
        RegCoef1:     coef_q[1]   <= coef_t'(cfg_data_i);
        RegCoef2:     coef_q[2]   <= coef_t'(cfg_data_i);
        RegCoef3:     coef_q[3]   <= coef_t'(cfg_data_i);
        RegCoef4:     coef_q[4]   <= coef_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Saturate half width and row width, detect the end of a row
  always_comb begin
    half_eff  = (half_q > HalfW'(MaxHalf)) ? HalfW'(MaxHalf) : half_q;
    width_ext = WidthW'(row_width_q);
    if (width_ext == '0) begin
      width_eff = WidthW'(1);
    end else if (width_ext > MaxWidth) begin
      width_eff = MaxWidth;
    end else begin
      width_eff = width_ext;
    end
    col_ext = WidthW'(col_q);
    is_last = (col_ext + WidthW'(1)) >= width_eff;
    has_res = is_last || (col_ext >= WidthW'(half_eff));
    col_lim = (col_ext >= WidthW'(MaxTaps - 1)) ? AgeW'(MaxTaps - 1) : AgeW'(col_q);
    if (is_last && (col_lim < AgeW'(half_eff))) begin
      dist_start = col_lim[HalfW-1:0];
    end else begin
      dist_start = half_eff;
    end
  end

  // Handshakes
  assign wk_fire    = wk_valid_q && (!out_valid_q || out_ready_i);
  assign wk_done    = (wk_q.lag == wk_q.dist_end);
  assign in_ready_o = !wk_valid_q || (wk_fire && wk_done);
  assign in_fire    = in_valid_i && in_ready_o;

  // Advance column counter and burst state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      wk_valid_q <= 1'b0;
    end else if (in_fire) begin
      col_q      <= is_last ? '0 : ColW'(col_q + ColW'(1));
      wk_valid_q <= has_res;
    end else if (wk_fire && wk_done) begin
      wk_valid_q <= 1'b0;
    end
  end

  // Shift in the new pixel, load or step the burst descriptor
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_q[0] <= pixel_i;
      for (int i = 1; i < MaxTaps; i++) begin
        win_q[i] <= win_q[i-1];
      end
      wk_q.lag      <= dist_start;
      wk_q.dist_end <= is_last ? '0 : half_eff;
      wk_q.half     <= half_eff;
      wk_q.col_lim  <= col_lim;
      wk_q.last     <= is_last;
    end else if (wk_fire && !wk_done) begin
      wk_q.lag <= wk_q.lag - HalfW'(1);
    end
  end

  // Weighted sum of the clamped neighbors of the current output column
  always_comb begin
    int                      age;
    logic [AgeW-1:0]         sel;
    logic signed [ProdW-1:0] coef_ext;
    logic signed [ProdW-1:0] pix_ext;
    logic signed [ProdW-1:0] prod;
    acc = '0;
    for (int i = 0; i < MaxTaps; i++) begin
      age = int'(wk_q.lag) + int'(wk_q.half) - i;
      if (age < 0) begin
        age = 0;
      end
      if (age > int'(wk_q.col_lim)) begin
        age = int'(wk_q.col_lim);
      end
      sel      = AgeW'(age);
      coef_ext = ProdW'(coef_q[i]);
      pix_ext  = $signed(ProdW'({1'b0, win_q[sel]}));
      prod     = coef_ext * pix_ext;
      if (i <= 2 * int'(wk_q.half)) begin
        acc = acc + AccW'(prod);
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wk_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wk_fire) begin
      filt_q       <= acc[FiltW-1:0];
      row_end_q    <= wk_q.last && (wk_q.lag == '0);
      burst_last_q <= wk_done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filt_q;
  assign row_end_o    = row_end_q;
  assign burst_last_o = burst_last_q;

endmodule

FILE: src/rcc_checker.sv
// Port-level checks for the row convolution block, bound to its top level.
module rcc_checker
  import rcc_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [FiltW-1:0] filtered_o,
  input logic                    row_end_o,
  input logic                    burst_last_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(filtered_o) && $stable(row_end_o) && $stable(burst_last_o))
    else $error("stalled result changed");

  // The last output of a row closes its burst
  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_end_o |-> burst_last_o)
    else $error("row end inside a burst");

  // Input is not ready while a stalled burst still has outputs pending
  a_burst_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !burst_last_o && !out_ready_i |-> !in_ready_o)
    else $error("pixel taken in the middle of a burst");

endmodule

bind row_convolution_clamp_edge rcc_checker u_rcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .filtered_o   (filtered_o),
  .row_end_o    (row_end_o),
  .burst_last_o (burst_last_o)
);
